>>> hw/rtl/pdlr_pkg.sv
// shared types and constants for the pcm downmix and linear resampler
`default_nettype none

package pdlr_pkg;

    // field and register widths
    localparam int SAMPLE_W  = 16;
    localparam int RATE_W    = 18;
    localparam int CC_W      = 4;
    localparam int OI_W      = 32;
    localparam int CFG_IDX_W = 2;

    // phase position output_index * source_rate
    localparam int POS_W     = OI_W + RATE_W;
    localparam int POS_IDX_W = $clog2(POS_W);
    localparam int STEP_W    = $clog2(POS_W + 1);

    // signed interpolation numerator and the quotient bits it needs
    localparam int NUM_W     = SAMPLE_W + RATE_W + 1;
    localparam int NUM_STEPS = NUM_W - 1;

    // results per input item
    localparam int RESULT_LIMIT = 16;
    localparam int RES_CNT_W    = $clog2(RESULT_LIMIT + 1);

    // configuration register indexes
    localparam logic [CFG_IDX_W-1:0] REG_CHANNEL_COUNT = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_SOURCE_RATE   = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_TARGET_RATE   = 2'd2;

    // configuration reset values
    localparam logic [CC_W-1:0]   RST_CHANNEL_COUNT = 4'd1;
    localparam logic [RATE_W-1:0] RST_RATE          = 18'd16000;

    // request to the serial divider
    typedef struct packed {
        logic                start;
        logic [STEP_W-1:0]   steps;
        logic [POS_W-1:0]    dividend;
        logic [RATE_W-1:0]   divisor;
    } div_req_t;

    // answer from the serial divider
    typedef struct packed {
        logic                done;
        logic [POS_W-1:0]    quotient;
        logic [RATE_W-1:0]   remainder;
    } div_rsp_t;

endpackage

`default_nettype wire

>>> hw/rtl/pcm_downmix_linear_resampler.sv
// top level: interleaved pcm downmix to mono and linear sample-rate conversion
`default_nettype none

// Interleaved signed 16-bit channel samples come in on the s_ stream, with
// s_tlast on the final sample of a stream. Each complete frame is averaged to
// mono (sum over the channel count, truncated toward zero) and the mono stream
// is linearly resampled from source_rate to target_rate, with exact integer
// arithmetic; at stream end the last mono value is repeated up to
// floor(frames * target / source) outputs and a partial frame is dropped.
// m_tlast marks the last output caused by one input item, m_tuser the final
// output of the stream. An item that does not close a frame is added to
// the channel sum; one that closes a frame is divided by the channel
// count, then each interpolated output it produces (at most 16) needs a
// phase and a value division: the single shared divider delivers one
// quotient bit per cycle and runs 50 steps for the phase position and 34
// steps for the interpolated value, with multiplier work and checks around it.
// Configuration writes are taken at any time but must only be issued while
// the block is idle.
module pcm_downmix_linear_resampler
    import pdlr_pkg::*;
#(
    parameter int MAX_CHANNELS = 8,
    parameter int MAX_UPSAMPLE = 16
)
(
    input  logic                 clk,
    input  logic                 rst_n,
    // input stream
    input  logic                 s_tvalid,
    output logic                 s_tready,
    input  logic [15:0]          s_tdata,   // [15:0] in_sample
    input  logic                 s_tlast,   // stream_last
    // output stream
    output logic                 m_tvalid,
    input  logic                 m_tready,
    output logic [15:0]          m_tdata,   // [15:0] out_sample
    output logic                 m_tlast,   // run_last
    output logic                 m_tuser,   // [0] stream_done
    // configuration writes
    input  logic                 cfg_valid,
    output logic                 cfg_ready,
    input  logic [CFG_IDX_W-1:0] cfg_index,
    input  logic [RATE_W-1:0]    cfg_data
);

    localparam int CNT_W   = $clog2(MAX_CHANNELS + 1);
    localparam int SUM_W   = 17 + $clog2(MAX_CHANNELS);
    localparam int SAT_W   = RATE_W + $clog2(MAX_UPSAMPLE + 1);
    localparam int MUL_A_W = OI_W + 2;
    localparam int MUL_B_W = RATE_W + 1;
    localparam int PROD_W  = MUL_A_W + MUL_B_W;

    typedef enum logic [14:0] {
        ST_IDLE  = 15'b000000000000001,
        ST_MGO   = 15'b000000000000010,
        ST_MWAIT = 15'b000000000000100,
        ST_TOP   = 15'b000000000001000,
        ST_EXL   = 15'b000000000010000,
        ST_EXR   = 15'b000000000100000,
        ST_EXC   = 15'b000000001000000,
        ST_POS   = 15'b000000010000000,
        ST_PGO   = 15'b000000100000000,
        ST_PWAIT = 15'b000001000000000,
        ST_CHK   = 15'b000010000000000,
        ST_M1    = 15'b000100000000000,
        ST_M2    = 15'b001000000000000,
        ST_NGO   = 15'b010000000000000,
        ST_NWAIT = 15'b100000000000000
    } state_t;

    // sequencer and configuration
    state_t                    state_reg, state_next;
    logic [CC_W-1:0]           cc_reg, cc_next;
    logic [RATE_W-1:0]         src_cfg_reg, src_cfg_next;
    logic [RATE_W-1:0]         tgt_cfg_reg, tgt_cfg_next;

    // stream state
    logic signed [SUM_W-1:0]   sum_reg, sum_next;
    logic [CNT_W-1:0]          idx_reg, idx_next;
    logic [SAMPLE_W-1:0]       prev_reg, prev_next;
    logic [SAMPLE_W-1:0]       latest_reg, latest_next;
    logic [OI_W-1:0]           oi_reg, oi_next;
    logic [OI_W-1:0]           fi_reg, fi_next;
    logic [SAMPLE_W-1:0]       held_reg, held_next;
    logic                      held_valid_reg, held_valid_next;

    // per item control
    logic                      last_reg, last_next;
    logic                      fin_reg, fin_next;
    logic                      flush_reg, flush_next;
    logic [RES_CNT_W-1:0]      cnt_reg, cnt_next;
    logic                      use_latest_reg, use_latest_next;

    // arithmetic holding registers
    logic signed [PROD_W-1:0]  prod_reg, prod_next;
    logic signed [PROD_W-1:0]  hold_reg, hold_next;
    logic signed [NUM_W-1:0]   num_reg, num_next;

    // pending result and output register
    logic [SAMPLE_W-1:0]       pend_reg, pend_next;
    logic                      pend_valid_reg, pend_valid_next;
    logic                      out_valid_reg, out_valid_next;
    logic [SAMPLE_W-1:0]       out_data_reg, out_data_next;
    logic                      out_last_reg, out_last_next;
    logic                      out_user_reg, out_user_next;

    // derived values
    logic [CNT_W-1:0]          ch_eff;
    logic [RATE_W-1:0]         src_eff;
    logic [RATE_W-1:0]         tgt_eff;
    logic [SAT_W-1:0]          src_sat;
    logic [RATE_W-1:0]         dst_eff;
    logic [CNT_W-1:0]          idx_inc;
    logic                      frame_done;
    logic signed [SUM_W-1:0]   sum_acc;
    logic [SUM_W-1:0]          sum_mag;
    logic [NUM_W-1:0]          num_mag;
    logic [SAMPLE_W-1:0]       q16;
    logic [SAMPLE_W-1:0]       q16_neg;
    logic [POS_W:0]            p_ext;
    logic [POS_W:0]            p_inc;
    logic [POS_W:0]            n_ext;
    logic                      interp_ok;
    logic                      out_free;
    logic                      end_fin;
    state_t                    end_state;
    logic signed [MUL_A_W-1:0] mul_a;
    logic signed [MUL_B_W-1:0] mul_b;
    logic signed [PROD_W-1:0]  num_sum;
    logic [SAMPLE_W-1:0]       interp_src;
    logic [RATE_W-1:0]         r_val;

    div_req_t                  div_req;
    div_rsp_t                  div_rsp;

    pdlr_div u_div (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (div_req),
        .rsp   (div_rsp)
    );

    // clamp channel count and rates
    always_comb
    begin
        if (cc_reg == '0)
            ch_eff = CNT_W'(1);
        else if (int'(cc_reg) > MAX_CHANNELS)
            ch_eff = CNT_W'(MAX_CHANNELS);
        else
            ch_eff = CNT_W'(cc_reg);
    end

    assign src_eff = (src_cfg_reg == '0) ? RATE_W'(1) : src_cfg_reg;
    assign tgt_eff = (tgt_cfg_reg == '0) ? RATE_W'(1) : tgt_cfg_reg;
    assign src_sat = SAT_W'(src_eff) * SAT_W'(MAX_UPSAMPLE);
    assign dst_eff = ({{(SAT_W-RATE_W){1'b0}}, tgt_eff} > src_sat) ?
                     src_sat[RATE_W-1:0] : tgt_eff;

    // channel accumulation
    assign idx_inc    = idx_reg + 1'b1;
    assign frame_done = idx_inc >= ch_eff;
    assign sum_acc    = sum_reg + {{(SUM_W-SAMPLE_W){s_tdata[SAMPLE_W-1]}}, s_tdata};

    // magnitudes for the divider and signed quotient
    assign sum_mag = sum_reg[SUM_W-1] ? SUM_W'(-sum_reg) : SUM_W'(sum_reg);
    assign num_mag = num_sum[PROD_W-1] ? NUM_W'(-num_sum) : NUM_W'(num_sum);
    assign q16     = div_rsp.quotient[SAMPLE_W-1:0];
    assign q16_neg = ~q16 + 1'b1;

    // phase position checks against the frame count
    assign r_val     = div_rsp.remainder;
    assign p_ext     = {1'b0, div_rsp.quotient};
    assign p_inc     = p_ext + 1'b1;
    assign n_ext     = {{(POS_W+1-OI_W){1'b0}}, fi_reg};
    assign interp_ok = (p_inc < n_ext) || ((r_val == '0) && (p_ext < n_ext));

    assign interp_src = use_latest_reg ? latest_reg : prev_reg;
    assign num_sum    = hold_reg + prod_reg;
    assign out_free   = !out_valid_reg || m_tready;

    // end of the drain or of the tail phase
    assign end_fin   = fin_reg || last_reg;
    assign end_state = (!fin_reg && last_reg) ? ST_TOP : ST_IDLE;

    // shared multiplier operands
    always_comb
    begin
        mul_a = '0;
        mul_b = '0;
        case (state_reg)
            ST_EXL:
            begin
                mul_a = {1'b0, {1'b0, oi_reg} + 1'b1};
                mul_b = {1'b0, src_eff};
            end
            ST_EXR, ST_EXC:
            begin
                mul_a = {2'b00, fi_reg};
                mul_b = {1'b0, dst_eff};
            end
            ST_POS:
            begin
                mul_a = {2'b00, oi_reg};
                mul_b = {1'b0, src_eff};
            end
            ST_M1:
            begin
                mul_a = {{(MUL_A_W-SAMPLE_W){interp_src[SAMPLE_W-1]}}, interp_src};
                mul_b = {1'b0, dst_eff - r_val};
            end
            ST_M2:
            begin
                mul_a = {{(MUL_A_W-SAMPLE_W){latest_reg[SAMPLE_W-1]}}, latest_reg};
                mul_b = {1'b0, r_val};
            end
            default:
            begin
                mul_a = '0;
                mul_b = '0;
            end
        endcase
    end

    // sequencer
    always_comb
    begin
        state_next      = state_reg;
        cc_next         = cc_reg;
        src_cfg_next    = src_cfg_reg;
        tgt_cfg_next    = tgt_cfg_reg;
        sum_next        = sum_reg;
        idx_next        = idx_reg;
        prev_next       = prev_reg;
        latest_next     = latest_reg;
        oi_next         = oi_reg;
        fi_next         = fi_reg;
        held_next       = held_reg;
        held_valid_next = held_valid_reg;
        last_next       = last_reg;
        fin_next        = fin_reg;
        flush_next      = flush_reg;
        cnt_next        = cnt_reg;
        use_latest_next = use_latest_reg;
        prod_next       = mul_a * mul_b;
        hold_next       = hold_reg;
        num_next        = num_reg;
        pend_next       = pend_reg;
        pend_valid_next = pend_valid_reg;
        out_valid_next  = out_valid_reg;
        out_data_next   = out_data_reg;
        out_last_next   = out_last_reg;
        out_user_next   = out_user_reg;
        div_req         = '0;

        // configuration writes
        if (cfg_valid)
        begin
            if (cfg_index == REG_CHANNEL_COUNT)
                cc_next = cfg_data[CC_W-1:0];
            else if (cfg_index == REG_SOURCE_RATE)
                src_cfg_next = cfg_data;
            else if (cfg_index == REG_TARGET_RATE)
                tgt_cfg_next = cfg_data;
        end

        // output register drains
        if (out_valid_reg && m_tready)
            out_valid_next = 1'b0;

        // flush the pending result once the item is finished
        if (flush_reg && (!pend_valid_reg || out_free))
        begin
            if (pend_valid_reg)
            begin
                out_valid_next = 1'b1;
                out_data_next  = pend_reg;
                out_last_next  = 1'b1;
                out_user_next  = last_reg;
            end
            pend_valid_next = 1'b0;
            flush_next      = 1'b0;
            if (last_reg)
            begin
                sum_next        = '0;
                idx_next        = '0;
                prev_next       = '0;
                latest_next     = '0;
                oi_next         = '0;
                fi_next         = '0;
                held_valid_next = 1'b0;
            end
        end

        case (state_reg)
            ST_IDLE:
            begin
                if (s_tvalid && !flush_reg)
                begin
                    last_next = s_tlast;
                    fin_next  = 1'b0;
                    cnt_next  = '0;
                    sum_next  = sum_acc;
                    if (frame_done)
                    begin
                        idx_next   = '0;
                        state_next = ST_MGO;
                    end
                    else
                    begin
                        idx_next = idx_inc;
                        if (s_tlast)
                        begin
                            fin_next   = 1'b1;
                            state_next = ST_TOP;
                        end
                    end
                end
            end
            ST_MGO:
            begin
                div_req.start    = 1'b1;
                div_req.steps    = STEP_W'(SUM_W);
                div_req.dividend = {{(POS_W-SUM_W){1'b0}}, sum_mag};
                div_req.divisor  = {{(RATE_W-CNT_W){1'b0}}, ch_eff};
                state_next       = ST_MWAIT;
            end
            ST_MWAIT:
            begin
                if (div_rsp.done)
                begin
                    prev_next   = latest_reg;
                    latest_next = sum_reg[SUM_W-1] ? q16_neg : q16;
                    fi_next     = fi_reg + 1'b1;
                    sum_next    = '0;
                    state_next  = ST_TOP;
                end
            end
            ST_TOP:
            begin
                if ((fi_reg == '0) || (cnt_reg == RES_CNT_W'(RESULT_LIMIT)))
                begin
                    fin_next   = end_fin;
                    flush_next = !(!fin_reg && last_reg);
                    state_next = end_state;
                end
                else if (held_valid_reg || fin_reg)
                    state_next = ST_EXL;
                else
                    state_next = ST_POS;
            end
            ST_EXL:
            begin
                state_next = ST_EXR;
            end
            ST_EXR:
            begin
                hold_next  = prod_reg;
                state_next = ST_EXC;
            end
            ST_EXC:
            begin
                // result exists: (output_index + 1) * src <= frames * dst
                if (hold_reg <= prod_reg)
                begin
                    if (!pend_valid_reg || out_free)
                    begin
                        if (pend_valid_reg)
                        begin
                            out_valid_next = 1'b1;
                            out_data_next  = pend_reg;
                            out_last_next  = 1'b0;
                            out_user_next  = 1'b0;
                        end
                        pend_next       = held_valid_reg ? held_reg : latest_reg;
                        pend_valid_next = 1'b1;
                        cnt_next        = cnt_reg + 1'b1;
                        oi_next         = oi_reg + 1'b1;
                        held_valid_next = 1'b0;
                        state_next      = ST_TOP;
                    end
                end
                else
                begin
                    fin_next   = end_fin;
                    flush_next = !(!fin_reg && last_reg);
                    state_next = end_state;
                end
            end
            ST_POS:
            begin
                state_next = ST_PGO;
            end
            ST_PGO:
            begin
                div_req.start    = 1'b1;
                div_req.steps    = STEP_W'(POS_W);
                div_req.dividend = prod_reg[POS_W-1:0];
                div_req.divisor  = dst_eff;
                state_next       = ST_PWAIT;
            end
            ST_PWAIT:
            begin
                if (div_rsp.done)
                    state_next = ST_CHK;
            end
            ST_CHK:
            begin
                use_latest_next = p_inc == n_ext;
                if (interp_ok)
                    state_next = ST_M1;
                else
                begin
                    fin_next   = end_fin;
                    flush_next = !(!fin_reg && last_reg);
                    state_next = end_state;
                end
            end
            ST_M1:
            begin
                state_next = ST_M2;
            end
            ST_M2:
            begin
                hold_next  = prod_reg;
                state_next = ST_NGO;
            end
            ST_NGO:
            begin
                // numerator sum formed here, its magnitude goes to the divider
                num_next         = num_sum[NUM_W-1:0];
                div_req.start    = 1'b1;
                div_req.steps    = STEP_W'(NUM_STEPS);
                div_req.dividend = {{(POS_W-NUM_W){1'b0}}, num_mag};
                div_req.divisor  = dst_eff;
                state_next       = ST_NWAIT;
            end
            ST_NWAIT:
            begin
                if (div_rsp.done)
                begin
                    held_next       = num_reg[NUM_W-1] ? q16_neg : q16;
                    held_valid_next = 1'b1;
                    state_next      = ST_TOP;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= ST_IDLE;
            cc_reg         <= RST_CHANNEL_COUNT;
            src_cfg_reg    <= RST_RATE;
            tgt_cfg_reg    <= RST_RATE;
            sum_reg        <= '0;
            idx_reg        <= '0;
            prev_reg       <= '0;
            latest_reg     <= '0;
            oi_reg         <= '0;
            fi_reg         <= '0;
            held_valid_reg <= 1'b0;
            last_reg       <= 1'b0;
            fin_reg        <= 1'b0;
            flush_reg      <= 1'b0;
            cnt_reg        <= '0;
            pend_valid_reg <= 1'b0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            state_reg      <= state_next;
            cc_reg         <= cc_next;
            src_cfg_reg    <= src_cfg_next;
            tgt_cfg_reg    <= tgt_cfg_next;
            sum_reg        <= sum_next;
            idx_reg        <= idx_next;
            prev_reg       <= prev_next;
            latest_reg     <= latest_next;
            oi_reg         <= oi_next;
            fi_reg         <= fi_next;
            held_valid_reg <= held_valid_next;
            last_reg       <= last_next;
            fin_reg        <= fin_next;
            flush_reg      <= flush_next;
            cnt_reg        <= cnt_next;
            pend_valid_reg <= pend_valid_next;
            out_valid_reg  <= out_valid_next;
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        held_reg       <= held_next;
        use_latest_reg <= use_latest_next;
        prod_reg       <= prod_next;
        hold_reg       <= hold_next;
        num_reg        <= num_next;
        pend_reg       <= pend_next;
        out_data_reg   <= out_data_next;
        out_last_reg   <= out_last_next;
        out_user_reg   <= out_user_next;
    end

    assign s_tready  = (state_reg == ST_IDLE) && !flush_reg;
    assign cfg_ready = 1'b1;
    assign m_tvalid  = out_valid_reg;
    assign m_tdata   = out_data_reg;
    assign m_tlast   = out_last_reg;
    assign m_tuser   = out_user_reg;

endmodule

`default_nettype wire

>>> hw/rtl/pdlr_div.sv
// unsigned restoring divider, one quotient bit per cycle
`default_nettype none

module pdlr_div
    import pdlr_pkg::*;
(
    input  logic     clk,
    input  logic     rst_n,
    input  div_req_t req,
    output div_rsp_t rsp
);

    logic                 busy_reg, busy_next;
    logic                 done_reg, done_next;
    logic [STEP_W-1:0]    step_reg, step_next;
    logic [POS_W-1:0]     dvd_reg, dvd_next;
    logic [RATE_W-1:0]    dvs_reg, dvs_next;
    logic [POS_W-1:0]     quo_reg, quo_next;
    logic [RATE_W-1:0]    rem_reg, rem_next;

    logic [POS_IDX_W-1:0] bit_idx;
    logic [STEP_W-1:0]    step_dec;
    logic [RATE_W:0]      trial;
    logic [RATE_W:0]      diff;
    logic                 ge;

    // bits are taken from position steps-1 down to zero
    assign step_dec = step_reg - 1'b1;
    assign bit_idx  = step_dec[POS_IDX_W-1:0];
    assign trial    = {rem_reg, dvd_reg[bit_idx]};
    assign ge       = trial >= {1'b0, dvs_reg};
    assign diff     = trial - {1'b0, dvs_reg};

    // load on start, then one subtract and compare per cycle
    always_comb
    begin
        busy_next = busy_reg;
        done_next = 1'b0;
        step_next = step_reg;
        dvd_next  = dvd_reg;
        dvs_next  = dvs_reg;
        quo_next  = quo_reg;
        rem_next  = rem_reg;
        if (req.start)
        begin
            busy_next = 1'b1;
            step_next = req.steps;
            dvd_next  = req.dividend;
            dvs_next  = req.divisor;
            quo_next  = '0;
            rem_next  = '0;
        end
        else if (busy_reg)
        begin
            rem_next  = ge ? diff[RATE_W-1:0] : trial[RATE_W-1:0];
            quo_next  = {quo_reg[POS_W-2:0], ge};
            step_next = step_dec;
            if (step_reg == STEP_W'(1))
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    // control
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            step_reg <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            step_reg <= step_next;
        end
    end

    // operands and partial results
    always_ff @(posedge clk)
    begin
        dvd_reg <= dvd_next;
        dvs_reg <= dvs_next;
        quo_reg <= quo_next;
        rem_reg <= rem_next;
    end

    assign rsp.done      = done_reg;
    assign rsp.quotient  = quo_reg;
    assign rsp.remainder = rem_reg;

endmodule

`default_nettype wire

>>> tb/pcm_downmix_linear_resampler_tb.sv
// testbench for the pcm downmix and linear resampler: directed cases, random streams, checker
module pcm_downmix_linear_resampler_tb;
    import pdlr_pkg::*;

    localparam int MAX_CH = 8;
    localparam int MAX_UP = 16;
    localparam logic [CFG_IDX_W-1:0] REG_UNUSED = 2'd3;
    // settling time after the last expected output; one item can produce up to 16 outputs
    localparam int SETTLE_CYCLES = 2000;
    // run limit for the whole test, above the worst case of all items at the burst limit plus settling
    localparam int CYCLE_LIMIT = 3000000;
    localparam int RANDOM_ITEMS = 100;

    typedef struct packed {
        logic [SAMPLE_W-1:0] smp;
        logic                run_end;
        logic                done;
    } mono_out_t;

    logic                 clk;
    logic                 rst_n;
    logic                 s_tvalid;
    logic                 s_tready;
    logic [15:0]          s_tdata;
    logic                 s_tlast;
    logic                 m_tvalid;
    logic                 m_tready;
    logic [15:0]          m_tdata;
    logic                 m_tlast;
    logic                 m_tuser;
    logic                 cfg_valid;
    logic                 cfg_ready;
    logic [CFG_IDX_W-1:0] cfg_index;
    logic [RATE_W-1:0]    cfg_data;

    // register values as last written
    logic [CC_W-1:0]      ch_reg;
    logic [RATE_W-1:0]    src_reg;
    logic [RATE_W-1:0]    dst_reg;

    // stream state of the predictor
    int                   frame_sum;
    int                   chan_pos;
    int                   prev_mono;
    int                   last_mono;
    logic [31:0]          out_count;
    logic [31:0]          frame_count;
    int                   held_mono;
    bit                   held_ok;

    mono_out_t            resampled_q[$];
    int                   err_cnt = 0;
    int                   cycle_cnt = 0;
    int                   gap_pct = 0;
    int                   stall_pct = 0;
    int                   stall_left = 0;
    int                   random_sent = 0;
    int                   rate_tab [0:8] = '{8000, 11025, 16000, 22050, 32000,
                                             44100, 48000, 96000, 192000};

    pcm_downmix_linear_resampler #(
        .MAX_CHANNELS (MAX_CH),
        .MAX_UPSAMPLE (MAX_UP)
    ) DUT (
        .clk       (clk),
        .rst_n     (rst_n),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tlast   (s_tlast),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tlast   (m_tlast),
        .m_tuser   (m_tuser),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    // clock
    initial
    begin
        clk = 1'b0;
        forever #2 clk = ~clk;
    end

    // cycle counter and run limit
    always @(posedge clk)
    begin
        cycle_cnt <= cycle_cnt + 1;
    end

    initial
    begin
        wait (cycle_cnt >= CYCLE_LIMIT);
        $display("RESULT: ERROR");
        $finish;
    end

    // output back-pressure: random stall bursts, started with a chance of stall_pct percent
    always @(posedge clk)
    begin
        if (stall_left > 0)
        begin
            stall_left = stall_left - 1;
            m_tready <= 1'b0;
        end
        else if ($urandom_range(0, 99) < stall_pct)
        begin
            stall_left = $urandom_range(0, 18);
            m_tready <= 1'b0;
        end
        else
            m_tready <= 1'b1;
    end

    // compare each output item with the oldest predicted one
    always @(posedge clk)
    begin : compare_resampled
        mono_out_t want;
        if (m_tvalid === 1'b1 && m_tready === 1'b1)
        begin
            if (resampled_q.size() == 0)
            begin
                $display("%0t: unexpected output item, expected none, got sample %0d last %b user %b",
                         $time, $signed(m_tdata), m_tlast, m_tuser);
                err_cnt++;
            end
            else
            begin
                want = resampled_q.pop_front();
                if (m_tdata !== want.smp)
                begin
                    $display("%0t: out_sample expected %0d got %0d",
                             $time, $signed(want.smp), $signed(m_tdata));
                    err_cnt++;
                end
                if (m_tlast !== want.run_end)
                begin
                    $display("%0t: run_last expected %b got %b", $time, want.run_end, m_tlast);
                    err_cnt++;
                end
                if (m_tuser !== want.done)
                begin
                    $display("%0t: stream_done expected %b got %b", $time, want.done, m_tuser);
                    err_cnt++;
                end
            end
        end
    end

    // channel count after clamping
    function automatic int eff_channels();
        if (ch_reg == 0)
            return 1;
        if (ch_reg > MAX_CH)
            return MAX_CH;
        return int'(ch_reg);
    endfunction

    function automatic mono_out_t mono_out(int v);
        mono_out_t o;
        o.smp = v[SAMPLE_W-1:0];
        o.run_end = 1'b0;
        o.done = 1'b0;
        return o;
    endfunction

    // output out_count lies inside the frames seen so far
    function automatic bit out_exists(longint unsigned src, longint unsigned dst);
        return ({32'd0, out_count} + 64'd1) * src <= {32'd0, frame_count} * dst;
    endfunction

    task automatic clear_stream();
        frame_sum = 0;
        chan_pos = 0;
        prev_mono = 0;
        last_mono = 0;
        out_count = '0;
        frame_count = '0;
        held_mono = 0;
        held_ok = 1'b0;
    endtask

    // downmix one sample and queue the resampled outputs it causes
    task automatic downmix_resample(input logic [15:0] smp, input logic lst);
        mono_out_t       burst[$];
        longint unsigned src;
        longint unsigned dst;
        longint unsigned pos;
        longint unsigned p;
        longint unsigned r;
        longint unsigned nfr;
        longint          a;
        longint          b;
        longint          num;
        int              nch;
        bit              stop;
        nch = eff_channels();
        src = (src_reg == 0) ? 1 : src_reg;
        dst = (dst_reg == 0) ? 1 : dst_reg;
        if (dst > src * MAX_UP)
            dst = src * MAX_UP;

        frame_sum = frame_sum + int'($signed(smp));
        chan_pos++;
        // frame complete: new mono value, then every output it makes reachable
        if (chan_pos >= nch)
        begin
            prev_mono = last_mono;
            last_mono = frame_sum / nch;
            frame_count++;
            frame_sum = 0;
            chan_pos = 0;
            nfr = {32'd0, frame_count};
            stop = (nfr == 0);
            while (!stop && burst.size() < RESULT_LIMIT)
            begin
                if (held_ok)
                begin
                    if (!out_exists(src, dst))
                        stop = 1'b1;
                    else
                    begin
                        burst.push_back(mono_out(held_mono));
                        out_count++;
                        held_ok = 1'b0;
                    end
                end
                else
                begin
                    pos = {32'd0, out_count} * src;
                    p = pos / dst;
                    r = pos % dst;
                    if (p + 1 < nfr || (r == 0 && p < nfr))
                    begin
                        a = (p + 1 == nfr) ? last_mono : prev_mono;
                        b = last_mono;
                        num = longint'(dst - r) * a + longint'(r) * b;
                        held_mono = int'(num / longint'(dst));
                        held_ok = 1'b1;
                    end
                    else
                        stop = 1'b1;
                end
            end
        end

        // stream end: pad with the last mono value, surplus past the burst limit is lost
        if (lst)
        begin
            if (frame_count != 0)
            begin
                stop = 1'b0;
                while (!stop && burst.size() < RESULT_LIMIT)
                begin
                    if (!out_exists(src, dst))
                        stop = 1'b1;
                    else if (held_ok)
                    begin
                        burst.push_back(mono_out(held_mono));
                        out_count++;
                        held_ok = 1'b0;
                    end
                    else
                    begin
                        burst.push_back(mono_out(last_mono));
                        out_count++;
                    end
                end
            end
            if (burst.size() > 0)
                burst[burst.size() - 1].done = 1'b1;
            clear_stream();
        end
        if (burst.size() > 0)
            burst[burst.size() - 1].run_end = 1'b1;
        foreach (burst[i])
            resampled_q.push_back(burst[i]);
    endtask

    // send one input item, with an optional gap before it
    task automatic push_sample(input logic [15:0] smp, input logic lst);
        if ($urandom_range(0, 99) < gap_pct)
        begin
            s_tvalid <= 1'b0;
            repeat ($urandom_range(1, 19)) @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= smp;
        s_tlast  <= lst;
        do @(posedge clk); while (s_tready !== 1'b1);
        downmix_resample(smp, lst);
    endtask

    // let every expected output arrive, then let the block settle
    task automatic wait_idle();
        s_tvalid <= 1'b0;
        while (resampled_q.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    // write all registers plus the unused index, cfg_valid held across the writes
    task automatic set_config(input logic [CC_W-1:0] ch, input logic [RATE_W-1:0] src,
                              input logic [RATE_W-1:0] dst);
        logic [RATE_W-1:0] ch_word;
        int                k;
        ch_word = RATE_W'(ch);
        if ($urandom_range(0, 3) == 0)
            ch_word[RATE_W-1:CC_W] = (RATE_W - CC_W)'($urandom);
        for (k = 0; k < 4; k++)
        begin
            cfg_valid <= 1'b1;
            case (k)
                0:
                begin
                    cfg_index <= REG_CHANNEL_COUNT;
                    cfg_data  <= ch_word;
                end
                1:
                begin
                    cfg_index <= REG_SOURCE_RATE;
                    cfg_data  <= src;
                end
                2:
                begin
                    cfg_index <= REG_TARGET_RATE;
                    cfg_data  <= dst;
                end
                default:
                begin
                    cfg_index <= REG_UNUSED;
                    cfg_data  <= RATE_W'($urandom);
                end
            endcase
            do @(posedge clk); while (cfg_ready !== 1'b1);
        end
        cfg_valid <= 1'b0;
        ch_reg  = ch;
        src_reg = src;
        dst_reg = dst;
    endtask

    function automatic logic [15:0] rand_sample();
        case ($urandom_range(0, 9))
            0: return 16'h7FFF;
            1: return 16'h8000;
            default: return 16'($urandom);
        endcase
    endfunction

    function automatic logic [RATE_W-1:0] rand_rate();
        if ($urandom_range(0, 9) < 7)
            return RATE_W'(rate_tab[$urandom_range(0, 8)]);
        return RATE_W'($urandom);
    endfunction

    // one stream: whole frames (in some with rates changed midway), or a broken ending, or noise
    task automatic random_stream(input bit allow_broken);
        int nfr;
        int nch;
        int kind;
        int k;
        int j;
        int extra;
        nch = eff_channels();
        nfr = $urandom_range(1, 6);
        kind = allow_broken ? $urandom_range(0, 9) : 0;
        if (kind == 9)
        begin
            // noise: length unrelated to the frame size
            extra = $urandom_range(1, 12);
            for (k = 0; k < extra; k++)
                push_sample(rand_sample(), k == extra - 1);
            random_sent += extra;
        end
        else
        begin
            for (k = 0; k < nfr; k++)
            begin
                // rates changed between frames
                if (kind == 8 && k > 0 && k == nfr / 2)
                begin
                    wait_idle();
                    set_config(ch_reg, rand_rate(), rand_rate());
                end
                for (j = 0; j < nch; j++)
                    push_sample(rand_sample(), kind != 7 && k == nfr - 1 && j == nch - 1);
                random_sent += nch;
            end
            // partial final frame
            if (kind == 7)
            begin
                extra = (nch > 1) ? $urandom_range(1, nch - 1) : 1;
                for (j = 0; j < extra; j++)
                    push_sample(rand_sample(), j == extra - 1);
                random_sent += extra;
            end
        end
    endtask

    // reset register values, equal rates, single channel
    task automatic test_reset_defaults();
        gap_pct = 0;
        stall_pct = 0;
        push_sample(16'h7FFF, 1'b0);
        push_sample(16'h8000, 1'b0);
        push_sample(16'hFFFF, 1'b0);
        push_sample(16'h0001, 1'b1);
    endtask

    // channel count above and at zero, extreme channel sum
    task automatic test_channel_clamp();
        int j;
        wait_idle();
        set_config(4'd15, 18'd48000, 18'd44100);
        for (j = 0; j < MAX_CH; j++)
            push_sample(16'h8000, j == MAX_CH - 1);
        wait_idle();
        set_config(4'd0, 18'd44100, 18'd48000);
        push_sample(16'h7FFF, 1'b0);
        push_sample(16'hFFFF, 1'b1);
    endtask

    // empty stream, truncation toward zero, partial final frame
    task automatic test_partial_and_empty();
        wait_idle();
        set_config(4'd2, 18'd16000, 18'd48000);
        push_sample(16'h1234, 1'b1);
        push_sample(16'hFFFD, 1'b0);
        push_sample(16'h0000, 1'b0);
        push_sample(16'h4000, 1'b1);
    endtask

    // target saturated at the upsample limit, burst limit, zero rates
    task automatic test_rate_edges();
        wait_idle();
        set_config(4'd1, 18'd1, 18'h3FFFF);
        push_sample(rand_sample(), 1'b0);
        push_sample(rand_sample(), 1'b0);
        push_sample(rand_sample(), 1'b1);
        wait_idle();
        set_config(4'd1, 18'd0, 18'd0);
        push_sample(16'h5A5A, 1'b0);
        push_sample(16'hA5A5, 1'b1);
    endtask

    // channel count lowered mid-frame, rates changed mid-stream
    task automatic test_midstream_changes();
        wait_idle();
        set_config(4'd3, 18'd44100, 18'd48000);
        push_sample(16'h7000, 1'b0);
        push_sample(16'h9000, 1'b0);
        wait_idle();
        set_config(4'd1, 18'd48000, 18'd32000);
        push_sample(16'h2222, 1'b0);
        push_sample(16'hDDDD, 1'b1);
    endtask

    // random settings and streams with idling on both sides
    task automatic test_random_streams();
        logic [CC_W-1:0]   ch;
        logic [RATE_W-1:0] src;
        logic [RATE_W-1:0] dst;
        longint            mult;
        int                nstr;
        int                k;
        while (random_sent < RANDOM_ITEMS)
        begin
            wait_idle();
            ch = ($urandom_range(0, 4) == 0) ? CC_W'($urandom) : CC_W'($urandom_range(1, MAX_CH));
            src = rand_rate();
            if ($urandom_range(0, 5) == 0)
            begin
                mult = longint'(src) * $urandom_range(1, 20);
                dst = (mult > 18'h3FFFF) ? 18'h3FFFF : RATE_W'(mult);
            end
            else
                dst = rand_rate();
            set_config(ch, src, dst);
            case ($urandom_range(0, 2))
                0: gap_pct = 0;
                1: gap_pct = 10;
                default: gap_pct = 35;
            endcase
            case ($urandom_range(0, 2))
                0: stall_pct = 0;
                1: stall_pct = 10;
                default: stall_pct = 35;
            endcase
            nstr = $urandom_range(1, 3);
            for (k = 0; k < nstr; k++)
                random_stream(1'b1);
        end
    endtask

    // closing part at full rate on both sides
    task automatic test_full_rate();
        int k;
        gap_pct = 0;
        stall_pct = 0;
        wait_idle();
        set_config(4'd2, 18'd32000, 18'd48000);
        for (k = 0; k < 3; k++)
            random_stream(1'b0);
    endtask

    // main sequence
    initial
    begin
        rst_n     = 1'b0;
        s_tvalid  = 1'b0;
        s_tdata   = '0;
        s_tlast   = 1'b0;
        m_tready  = 1'b0;
        cfg_valid = 1'b0;
        cfg_index = '0;
        cfg_data  = '0;
        ch_reg    = RST_CHANNEL_COUNT;
        src_reg   = RST_RATE;
        dst_reg   = RST_RATE;
        clear_stream();
        repeat (9) @(posedge clk);
        rst_n <= 1'b1;

        test_reset_defaults();
        test_channel_clamp();
        test_partial_and_empty();
        test_rate_edges();
        test_midstream_changes();
        test_random_streams();
        test_full_rate();

        wait_idle();
        if (err_cnt == 0)
            $display("RESULT: OK");
        else
            $display("RESULT: ERROR");
        $finish;
    end

endmodule
